// ===== hdl/uart_buffered_tx_rx_idle_timeout_core_macros.svh =====
// ----------------------------------------------------------------------------
// uart buffered tx/rx core assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef UART_BUFFERED_TX_RX_IDLE_TIMEOUT_CORE_MACROS_SVH
`define UART_BUFFERED_TX_RX_IDLE_TIMEOUT_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define UBT_ASSERT_IMPLY(name, ck, rst_n, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ubt port check failed");

// next-cycle implication, disabled while in reset
`define UBT_ASSERT_NEXT(name, ck, rst_n, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ubt port check failed");

`endif

// ===== hdl/ubt_pkg.sv =====
// ----------------------------------------------------------------------------
// ubt_pkg
// types and constants shared by the buffered uart core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ubt_pkg;

	localparam int TX_DEPTH = 16;
	localparam int RX_DEPTH = 32;

	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int TX_CW = $clog2(TX_DEPTH + 1);
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int RX_CW = $clog2(RX_DEPTH + 1);

	localparam int FUNC_W     = 3;
	localparam int BYTE_W     = 8;
	localparam int TMO_W      = 16;
	localparam int RX_COUNT_W = 6;

	localparam logic [TMO_W-1:0] IDLE_RELOAD_RST = 16'd5;

	localparam int CMDQ_DEPTH = 2;
	localparam int OUTQ_DEPTH = 2;

	// event codes on the func port
	localparam logic [FUNC_W-1:0] FUNC_TX_WRITE = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_TX_DONE  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_RX_BYTE  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_START_RX = 3'd4;

	typedef enum logic [2:0] {
		OP_TX_WRITE,
		OP_TX_DONE,
		OP_RX_BYTE,
		OP_TICK,
		OP_START_RX,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data;
		logic [TMO_W-1:0]  tmo;
	} cmd_t;

	typedef struct packed {
		logic                  tx_valid;
		logic [BYTE_W-1:0]     tx_byte;
		logic                  tx_busy;
		logic                  tx_overflow;
		logic                  rx_valid;
		logic [BYTE_W-1:0]     rx_byte;
		logic [RX_COUNT_W-1:0] rx_count;
		logic                  last;
	} res_t;

endpackage

`default_nettype wire

// ===== hdl/ubt_front.sv =====
// ----------------------------------------------------------------------------
// ubt_front
// accepts events, decodes func and holds them in a short command queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ubt_front import ubt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [FUNC_W-1:0] func,
	input  logic [BYTE_W-1:0] data,
	input  logic [TMO_W-1:0]  timeout,
	output logic              cmd_avail,
	output cmd_t              cmd_head,
	input  logic              cmd_pop
);

	localparam int AW = $clog2(CMDQ_DEPTH);
	localparam int CW = $clog2(CMDQ_DEPTH + 1);

	cmd_t          q_mem [CMDQ_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	cmd_t          cmd_in;
	logic          accept;
	logic          take;

	// classify the event
	always_comb begin
		cmd_in.data = data;
		cmd_in.tmo  = timeout;
		case (func)
			FUNC_TX_WRITE: cmd_in.op = OP_TX_WRITE;
			FUNC_TX_DONE:  cmd_in.op = OP_TX_DONE;
			FUNC_RX_BYTE:  cmd_in.op = OP_RX_BYTE;
			FUNC_TICK:     cmd_in.op = OP_TICK;
			FUNC_START_RX: cmd_in.op = OP_START_RX;
			default:       cmd_in.op = OP_NOP;
		endcase
	end

	assign full      = (count_q == CW'(CMDQ_DEPTH));
	assign cmd_avail = (count_q != '0);
	assign cmd_head  = q_mem[rd_ptr_q];
	assign accept    = push && !full;
	assign take      = cmd_pop && cmd_avail;

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (wr_ptr_q == AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(accept) - CW'(take);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ubt_back.sv =====
// ----------------------------------------------------------------------------
// ubt_back
// executes decoded events against the tx ring, rx buffer and idle timer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ubt_back import ubt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [TMO_W-1:0] cfg_wr_data,
	input  logic             cmd_avail,
	input  cmd_t             cmd_head,
	output logic             cmd_pop,
	input  logic             res_space,
	output logic             res_push,
	output res_t             res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_TXRD,
		S_RES,
		S_DRAIN
	} state_t;

	state_t            state_q;
	logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
	logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
	logic [TX_AW-1:0]  tx_rp_q;
	logic [TX_AW-1:0]  tx_wp_q;
	logic [TX_CW-1:0]  tx_fill_q;
	logic              tx_busy_q;
	logic [RX_CW-1:0]  rx_fill_q;
	logic [TMO_W-1:0]  timer_q;
	logic              receiving_q;
	logic [TMO_W-1:0]  idle_reload_q;
	logic              txv_q;
	logic [BYTE_W-1:0] txb_q;
	logic              ovf_q;
	logic [RX_CW-1:0]  n_q;
	logic [RX_AW-1:0]  idx_q;
	logic [BYTE_W-1:0] rxb_q;

	logic             tx_room;
	logic             tx_wr_en;
	logic             rx_wr_en;
	logic             rx_wrap;
	logic [RX_AW-1:0] rx_wr_idx;
	logic             drain_last;

	assign cmd_pop    = (state_q == S_IDLE) && cmd_avail;
	assign tx_room    = (tx_fill_q < TX_CW'(TX_DEPTH));
	assign tx_wr_en   = cmd_pop && (cmd_head.op == OP_TX_WRITE) && tx_room;
	assign rx_wr_en   = cmd_pop && (cmd_head.op == OP_RX_BYTE);
	// a full rx buffer wraps to entry zero
	assign rx_wrap    = (rx_fill_q >= RX_CW'(RX_DEPTH));
	assign rx_wr_idx  = rx_wrap ? '0 : rx_fill_q[RX_AW-1:0];
	assign drain_last = ((RX_CW'(idx_q) + RX_CW'(1)) == n_q);

	always_ff @(posedge clk) begin
		if (tx_wr_en) begin
			tx_mem[tx_wp_q] <= cmd_head.data;
		end
		if (rx_wr_en) begin
			rx_mem[rx_wr_idx] <= cmd_head.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			tx_rp_q       <= '0;
			tx_wp_q       <= '0;
			tx_fill_q     <= '0;
			tx_busy_q     <= 1'b0;
			rx_fill_q     <= '0;
			timer_q       <= '0;
			receiving_q   <= 1'b0;
			idle_reload_q <= IDLE_RELOAD_RST;
			txv_q         <= 1'b0;
			txb_q         <= '0;
			ovf_q         <= 1'b0;
			n_q           <= '0;
			idx_q         <= '0;
			rxb_q         <= '0;
		end else begin
			if (cfg_wr_en) begin
				idle_reload_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_avail) begin
						txv_q <= 1'b0;
						txb_q <= '0;
						// a write into a full ring is dropped and flagged
						ovf_q <= (cmd_head.op == OP_TX_WRITE) && !tx_room;
						case (cmd_head.op)
							OP_TX_WRITE: begin
								if (tx_room) begin
									tx_wp_q   <= (tx_wp_q == TX_AW'(TX_DEPTH - 1)) ?
										'0 : tx_wp_q + TX_AW'(1);
									tx_fill_q <= tx_fill_q + TX_CW'(1);
								end
								// idle transmitter takes the next byte at once
								if (!tx_busy_q) begin
									tx_busy_q <= 1'b1;
									state_q   <= S_TXRD;
								end else begin
									state_q   <= S_RES;
								end
							end
							OP_TX_DONE: begin
								state_q <= S_TXRD;
							end
							OP_RX_BYTE: begin
								rx_fill_q <= rx_wrap ? RX_CW'(1) : rx_fill_q + RX_CW'(1);
								timer_q   <= idle_reload_q;
								state_q   <= S_RES;
							end
							OP_TICK: begin
								if (receiving_q && (timer_q != '0)) begin
									timer_q <= timer_q - TMO_W'(1);
									if (timer_q == TMO_W'(1)) begin
										// expiry: hand out the collected frame
										rx_fill_q   <= '0;
										receiving_q <= 1'b0;
										n_q         <= rx_fill_q;
										idx_q       <= '0;
										rxb_q       <= rx_mem[RX_AW'(0)];
										state_q     <= (rx_fill_q != '0) ? S_DRAIN : S_RES;
									end else begin
										state_q <= S_RES;
									end
								end else begin
									state_q <= S_RES;
								end
							end
							OP_START_RX: begin
								timer_q     <= cmd_head.tmo;
								receiving_q <= 1'b1;
								state_q     <= S_RES;
							end
							default: begin
								state_q <= S_RES;
							end
						endcase
					end
				end
				S_TXRD: begin
					if (tx_fill_q != '0) begin
						txv_q     <= 1'b1;
						txb_q     <= tx_mem[tx_rp_q];
						tx_rp_q   <= (tx_rp_q == TX_AW'(TX_DEPTH - 1)) ?
							'0 : tx_rp_q + TX_AW'(1);
						tx_fill_q <= tx_fill_q - TX_CW'(1);
					end else begin
						tx_busy_q <= 1'b0;
					end
					state_q <= S_RES;
				end
				S_RES: begin
					if (res_space) begin
						state_q <= S_IDLE;
					end
				end
				S_DRAIN: begin
					if (res_space) begin
						if (drain_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + RX_AW'(1);
							rxb_q <= rx_mem[idx_q + RX_AW'(1)];
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_push = ((state_q == S_RES) || (state_q == S_DRAIN)) && res_space;

	always_comb begin
		res.tx_busy = tx_busy_q;
		if (state_q == S_DRAIN) begin
			res.tx_valid    = 1'b0;
			res.tx_byte     = '0;
			res.tx_overflow = 1'b0;
			res.rx_valid    = 1'b1;
			res.rx_byte     = rxb_q;
			res.rx_count    = RX_COUNT_W'(n_q);
			res.last        = drain_last;
		end else begin
			res.tx_valid    = txv_q;
			res.tx_byte     = txb_q;
			res.tx_overflow = ovf_q;
			res.rx_valid    = 1'b0;
			res.rx_byte     = '0;
			res.rx_count    = '0;
			res.last        = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ubt_outq.sv =====
// ----------------------------------------------------------------------------
// ubt_outq
// small result queue that decouples the execution side from the reader
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ubt_outq import ubt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_push,
	input  res_t in_item,
	output logic has_space,
	output logic out_empty,
	output res_t out_item,
	input  logic out_pop
);

	localparam int AW = $clog2(OUTQ_DEPTH);
	localparam int CW = $clog2(OUTQ_DEPTH + 1);

	res_t          q_mem [OUTQ_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          wr;
	logic          rd;

	assign has_space = (count_q != CW'(OUTQ_DEPTH));
	assign out_empty = (count_q == '0);
	assign out_item  = q_mem[rd_ptr_q];
	assign wr        = in_push && has_space;
	assign rd        = out_pop && !out_empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			q_mem[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(wr) - CW'(rd);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/uart_buffered_tx_rx_idle_timeout_core.sv =====
// flow: the front queues each event; the back executes it from S_IDLE, via
// S_TXRD for a write while the transmitter is idle and for tx done, and pushes
// its result from S_RES, taking no new event before then; it stalls while
// the output queue is full, and an expiry of n frame bytes gives n results
// reset: arst_n clears pointers, counts, flags and queues; idle_reload is 5
// ----------------------------------------------------------------------------
// uart_buffered_tx_rx_idle_timeout_core
// buffered uart front end: tx ring, rx frame buffer and idle timeout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uart_buffered_tx_rx_idle_timeout_core import ubt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// event side
	input  logic                  push,
	output logic                  full,
	input  logic [FUNC_W-1:0]     func,
	input  logic [BYTE_W-1:0]     data,
	input  logic [TMO_W-1:0]      timeout,
	// idle reload register
	input  logic                  cfg_wr_en,
	input  logic [TMO_W-1:0]      cfg_wr_data,
	// result side
	output logic                  empty,
	input  logic                  pop,
	output logic                  tx_valid,
	output logic [BYTE_W-1:0]     tx_byte,
	output logic                  tx_busy,
	output logic                  tx_overflow,
	output logic                  rx_valid,
	output logic [BYTE_W-1:0]     rx_byte,
	output logic [RX_COUNT_W-1:0] rx_count,
	output logic                  last
);

	// decoded command between front and back
	logic cmd_avail;
	cmd_t cmd_head;
	logic cmd_pop;

	// result transaction into the output queue
	logic res_space;
	logic res_push;
	res_t res;
	res_t out_item;

	// front: accept each event transaction and decode func into an opcode
	ubt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.data      (data),
		.timeout   (timeout),
		.cmd_avail (cmd_avail),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop)
	);

	// back: owns all uart state; one command at a time, frame drain at expiry
	ubt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_avail   (cmd_avail),
		.cmd_head    (cmd_head),
		.cmd_pop     (cmd_pop),
		.res_space   (res_space),
		.res_push    (res_push),
		.res         (res)
	);

	// output queue: back keeps working while the reader holds off pop, until it fills
	ubt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_push   (res_push),
		.in_item   (res),
		.has_space (res_space),
		.out_empty (empty),
		.out_item  (out_item),
		.out_pop   (pop)
	);

	// oldest result on the ports
	assign tx_valid    = out_item.tx_valid;
	assign tx_byte     = out_item.tx_byte;
	assign tx_busy     = out_item.tx_busy;
	assign tx_overflow = out_item.tx_overflow;
	assign rx_valid    = out_item.rx_valid;
	assign rx_byte     = out_item.rx_byte;
	assign rx_count    = out_item.rx_count;
	assign last        = out_item.last;

endmodule

`default_nettype wire

// ===== hdl/ubt_port_checker.sv =====
// ----------------------------------------------------------------------------
// ubt_port_checker
// port-level checks on the result side of the buffered uart core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "uart_buffered_tx_rx_idle_timeout_core_macros.svh"

module ubt_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       tx_valid,
	input logic [7:0] tx_byte,
	input logic       tx_busy,
	input logic       tx_overflow,
	input logic       rx_valid,
	input logic [7:0] rx_byte,
	input logic [5:0] rx_count,
	input logic       last
);

	// a waiting result holds until popped
	`UBT_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(tx_byte) && $stable(rx_byte) && $stable(last))

	// frame bytes carry no tx activity and a nonzero length
	`UBT_ASSERT_IMPLY(a_rx_item, clk, arst_n, !empty && rx_valid, !tx_valid && !tx_overflow && (rx_count != 6'd0))

	// status results are single and clean on the rx side
	`UBT_ASSERT_IMPLY(a_status, clk, arst_n, !empty && !rx_valid, last && (rx_byte == 8'd0) && (rx_count == 6'd0))

	// a handed-out byte leaves the transmitter busy
	`UBT_ASSERT_IMPLY(a_tx_busy, clk, arst_n, !empty && tx_valid, tx_busy)

endmodule

bind uart_buffered_tx_rx_idle_timeout_core ubt_port_checker u_port_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the buffered uart core
// scoreboard tracks the tx ring, the rx frame buffer and the idle timer
// directed table first, then random tx bursts, rx frames and noise
// under several idle reload settings, random idling on both queue sides
// ----------------------------------------------------------------------------

module testbench;
	import ubt_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 22;
	localparam int NUM_PHASES  = 5;
	localparam int NUM_ROWS    = 25;

	// func codes with no event behind them, the core treats them as a no-op
	localparam logic [FUNC_W-1:0] FUNC_RSVD_5 = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

	// hand-written status words for the directed table
	localparam res_t ST_QUIET    = '{last: 1'b1, default: '0};
	localparam res_t ST_BUSY     = '{tx_busy: 1'b1, last: 1'b1, default: '0};
	localparam res_t ST_HAND_00  = '{tx_valid: 1'b1, tx_byte: 8'h00, tx_busy: 1'b1,
		last: 1'b1, default: '0};
	localparam res_t ST_HAND_FF  = '{tx_valid: 1'b1, tx_byte: 8'hFF, tx_busy: 1'b1,
		last: 1'b1, default: '0};
	localparam res_t ST_OVERFLOW = '{tx_busy: 1'b1, tx_overflow: 1'b1, last: 1'b1,
		default: '0};
	localparam res_t ST_NONE     = '0;

	typedef struct {
		logic [FUNC_W-1:0] f;
		logic [BYTE_W-1:0] d;
		logic [TMO_W-1:0]  t;
		int                reps;
		bit                typed;
		res_t              want;
	} dir_row_t;

	// directed table: the byte column advances by one on each repeat
	dir_row_t dir_rows [NUM_ROWS] = '{
		// tick while not receiving, tx done with nothing queued
		'{FUNC_TICK,     8'h00, 16'h0000, 1,  1'b1, ST_QUIET},
		'{FUNC_TX_DONE,  8'h00, 16'h0000, 1,  1'b1, ST_QUIET},
		// write while idle goes straight out, second one is queued
		'{FUNC_TX_WRITE, 8'h00, 16'h0000, 1,  1'b1, ST_HAND_00},
		'{FUNC_TX_WRITE, 8'hFF, 16'hFFFF, 1,  1'b1, ST_BUSY},
		'{FUNC_TX_DONE,  8'h00, 16'h0000, 1,  1'b1, ST_HAND_FF},
		'{FUNC_TX_DONE,  8'h00, 16'h0000, 1,  1'b1, ST_QUIET},
		// unused func codes
		'{FUNC_RSVD_5,   8'hAA, 16'hFFFF, 1,  1'b1, ST_QUIET},
		'{FUNC_RSVD_6,   8'h55, 16'h0001, 1,  1'b1, ST_QUIET},
		'{FUNC_RSVD_7,   8'hFF, 16'hFFFF, 1,  1'b1, ST_QUIET},
		// armed with timeout zero, ticks do nothing
		'{FUNC_START_RX, 8'h00, 16'h0000, 1,  1'b1, ST_QUIET},
		'{FUNC_TICK,     8'h00, 16'h0000, 1,  1'b1, ST_QUIET},
		// expiry with an empty frame
		'{FUNC_START_RX, 8'h00, 16'h0002, 1,  1'b1, ST_QUIET},
		'{FUNC_TICK,     8'h00, 16'h0000, 1,  1'b1, ST_QUIET},
		'{FUNC_TICK,     8'h00, 16'h0000, 1,  1'b1, ST_QUIET},
		// bytes outside reception are kept
		'{FUNC_RX_BYTE,  8'h00, 16'h0000, 1,  1'b1, ST_QUIET},
		'{FUNC_RX_BYTE,  8'hFF, 16'hFFFF, 1,  1'b1, ST_QUIET},
		// restart while armed keeps the frame
		'{FUNC_START_RX, 8'h00, 16'hFFFF, 1,  1'b1, ST_QUIET},
		'{FUNC_START_RX, 8'h00, 16'h0001, 1,  1'b1, ST_QUIET},
		'{FUNC_TICK,     8'h00, 16'h0000, 1,  1'b0, ST_NONE},
		// fill the ring, then one write too many
		'{FUNC_TX_WRITE, 8'h10, 16'h0000, 17, 1'b0, ST_NONE},
		'{FUNC_TX_WRITE, 8'hC3, 16'h0000, 1,  1'b1, ST_OVERFLOW},
		'{FUNC_TX_DONE,  8'h00, 16'h0000, 17, 1'b0, ST_NONE},
		// rx buffer wraps, the frame restarts at entry 0
		'{FUNC_RX_BYTE,  8'h80, 16'h0000, 33, 1'b0, ST_NONE},
		'{FUNC_START_RX, 8'h00, 16'h0001, 1,  1'b1, ST_QUIET},
		'{FUNC_TICK,     8'h00, 16'h0000, 1,  1'b0, ST_NONE}
	};

	// idle reload per random phase, -1 picks a small random value
	int reload_plan [NUM_PHASES] = '{1, 65535, 0, 3, -1};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [FUNC_W-1:0]     func = '0;
	logic [BYTE_W-1:0]     data = '0;
	logic [TMO_W-1:0]      timeout = '0;
	logic                  cfg_wr_en = 1'b0;
	logic [TMO_W-1:0]      cfg_wr_data = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic                  tx_valid;
	logic [BYTE_W-1:0]     tx_byte;
	logic                  tx_busy;
	logic                  tx_overflow;
	logic                  rx_valid;
	logic [BYTE_W-1:0]     rx_byte;
	logic [RX_COUNT_W-1:0] rx_count;
	logic                  last;

	// scoreboard model state
	logic [BYTE_W-1:0] ring_mem [TX_DEPTH];
	int                ring_rd = 0;
	int                ring_wr = 0;
	int                ring_level = 0;
	logic              tx_is_busy = 1'b0;
	logic [BYTE_W-1:0] frame_mem [RX_DEPTH];
	int                frame_level = 0;
	logic [TMO_W-1:0]  idle_ticks = '0;
	logic              rx_armed = 1'b0;
	logic [TMO_W-1:0]  reload_val = IDLE_RELOAD_RST;

	res_t step_out [$];
	res_t expected_q [$];

	bit steady = 1'b0;
	int cycles = 0;
	int items_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int frames_out = 0;
	int overflows = 0;

	uart_buffered_tx_rx_idle_timeout_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.func        (func),
		.data        (data),
		.timeout     (timeout),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.empty       (empty),
		.pop         (pop),
		.tx_valid    (tx_valid),
		.tx_byte     (tx_byte),
		.tx_busy     (tx_busy),
		.tx_overflow (tx_overflow),
		.rx_valid    (rx_valid),
		.rx_byte     (rx_byte),
		.rx_count    (rx_count),
		.last        (last)
	);

	always #HALF_PERIOD clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycles, expected_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// one status word, busy always reflects the model after the event
	function automatic res_t status_word(logic txv, logic [BYTE_W-1:0] txb, logic ovf,
		logic rxv, logic [BYTE_W-1:0] rxb, logic [RX_COUNT_W-1:0] cnt, logic lst);
		res_t r;
		r.tx_valid    = txv;
		r.tx_byte     = txb;
		r.tx_busy     = tx_is_busy;
		r.tx_overflow = ovf;
		r.rx_valid    = rxv;
		r.rx_byte     = rxb;
		r.rx_count    = cnt;
		r.last        = lst;
		return r;
	endfunction

	function automatic string res_text(res_t r);
		return $sformatf("txv=%0b txb=%02h busy=%0b ovf=%0b rxv=%0b rxb=%02h cnt=%0d last=%0b",
			r.tx_valid, r.tx_byte, r.tx_busy, r.tx_overflow, r.rx_valid, r.rx_byte,
			r.rx_count, r.last);
	endfunction

	// tx done action: next queued byte out, or the transmitter goes idle
	task automatic ring_handoff(output logic got, output logic [BYTE_W-1:0] b);
		if (ring_level > 0) begin
			b = ring_mem[ring_rd];
			ring_rd = (ring_rd + 1) % TX_DEPTH;
			ring_level--;
			got = 1'b1;
		end else begin
			tx_is_busy = 1'b0;
			b = '0;
			got = 1'b0;
		end
	endtask

	// advance the model by one event and leave its transactions in step_out
	task automatic predict_uart_event(input logic [FUNC_W-1:0] f,
		input logic [BYTE_W-1:0] d, input logic [TMO_W-1:0] t);
		logic              handed;
		logic [BYTE_W-1:0] b;
		logic              ovf;
		int                n;
		bit                framed;
		handed = 1'b0;
		b = '0;
		ovf = 1'b0;
		framed = 1'b0;
		step_out.delete();
		case (f)
			FUNC_TX_WRITE: begin
				if (ring_level < TX_DEPTH) begin
					ring_mem[ring_wr] = d;
					ring_wr = (ring_wr + 1) % TX_DEPTH;
					ring_level++;
				end else begin
					ovf = 1'b1;
					overflows++;
				end
				if (!tx_is_busy) begin
					tx_is_busy = 1'b1;
					ring_handoff(handed, b);
				end
			end
			FUNC_TX_DONE: begin
				ring_handoff(handed, b);
			end
			FUNC_RX_BYTE: begin
				if (frame_level >= RX_DEPTH)
					frame_level = 0;
				frame_mem[frame_level] = d;
				frame_level++;
				idle_ticks = reload_val;
			end
			FUNC_TICK: begin
				if (rx_armed && idle_ticks != 0) begin
					idle_ticks--;
					if (idle_ticks == 0) begin
						// expiry: the whole frame goes out, an empty one as a plain status
						n = frame_level;
						frame_level = 0;
						rx_armed = 1'b0;
						framed = (n != 0);
						for (int i = 0; i < n; i++)
							step_out.push_back(status_word(1'b0, '0, 1'b0, 1'b1, frame_mem[i],
								RX_COUNT_W'(n), i == n - 1));
						if (framed)
							frames_out++;
					end
				end
			end
			FUNC_START_RX: begin
				idle_ticks = t;
				rx_armed = 1'b1;
			end
			default: begin
			end
		endcase
		if (!framed)
			step_out.push_back(status_word(handed, handed ? b : '0, ovf, 1'b0, '0, '0, 1'b1));
	endtask

	// one event transaction; push stays high when the next event follows at once
	task automatic send_event(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] d,
		input logic [TMO_W-1:0] t, input bit typed, input res_t want);
		while (!steady && $urandom_range(0, 99) < 33) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		func <= f;
		data <= d;
		timeout <= t;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_uart_event(f, d, t);
		items_sent++;
		if (typed)
			expected_q.push_back(want);
		else
			foreach (step_out[k])
				expected_q.push_back(step_out[k]);
	endtask

	// push low and every transaction drained, so the core sits idle
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idle_reload(input logic [TMO_W-1:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		reload_val = v;
	endtask

	// one random sequence: an rx frame, a tx burst or a few noise events
	task automatic random_burst();
		int kind;
		int n;
		int budget;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			send_event(FUNC_START_RX, BYTE_W'($urandom_range(0, 255)),
				($urandom_range(0, 7) == 0) ? TMO_W'($urandom_range(0, 65535))
					: TMO_W'($urandom_range(0, 4)),
				1'b0, ST_NONE);
			// mostly short frames, now and then a long one that may wrap the buffer
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
			for (int k = 0; k < n; k++) begin
				send_event(FUNC_RX_BYTE, BYTE_W'($urandom_range(0, 255)),
					TMO_W'($urandom_range(0, 65535)), 1'b0, ST_NONE);
				if ($urandom_range(0, 3) == 0)
					send_event(FUNC_TICK, BYTE_W'($urandom_range(0, 255)),
						TMO_W'($urandom_range(0, 65535)), 1'b0, ST_NONE);
			end
			// tick until the frame expires, unless the timer is out of reach
			budget = 10;
			while (rx_armed && budget > 0) begin
				send_event(FUNC_TICK, BYTE_W'($urandom_range(0, 255)),
					TMO_W'($urandom_range(0, 65535)), 1'b0, ST_NONE);
				budget--;
			end
		end else if (kind < 7) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 6);
			for (int k = 0; k < n; k++)
				send_event(FUNC_TX_WRITE, BYTE_W'($urandom_range(0, 255)),
					TMO_W'($urandom_range(0, 65535)), 1'b0, ST_NONE);
			n = $urandom_range(0, n + 2);
			for (int k = 0; k < n; k++)
				send_event(FUNC_TX_DONE, BYTE_W'($urandom_range(0, 255)),
					TMO_W'($urandom_range(0, 65535)), 1'b0, ST_NONE);
		end else begin
			n = $urandom_range(1, 4);
			for (int k = 0; k < n; k++)
				send_event(FUNC_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
					TMO_W'($urandom_range(0, 65535)), 1'b0, ST_NONE);
		end
	endtask

	// result side: random pop stalls, check every accepted transaction
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && pop && !empty) begin
			got.tx_valid    = tx_valid;
			got.tx_byte     = tx_byte;
			got.tx_busy     = tx_busy;
			got.tx_overflow = tx_overflow;
			got.rx_valid    = rx_valid;
			got.rx_byte     = rx_byte;
			got.rx_count    = rx_count;
			got.last        = last;
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d with nothing expected: %s", results_seen, res_text(got));
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d mismatch\n  expected %s\n  actual   %s",
							results_seen, res_text(want), res_text(got));
				end
			end
		end
		pop <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
	end

	initial begin
		int target;
		int directed_items;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, idle reload still at its reset value
		foreach (dir_rows[i])
			for (int r = 0; r < dir_rows[i].reps; r++)
				send_event(dir_rows[i].f, dir_rows[i].d + BYTE_W'(r), dir_rows[i].t,
					dir_rows[i].typed, dir_rows[i].want);
		directed_items = items_sent;

		// random phases, one reload setting each, the fourth without any idling
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_idle_reload((reload_plan[p] < 0) ? TMO_W'($urandom_range(1, 12))
				: TMO_W'(reload_plan[p]));
			steady = (p == 3);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_burst();
		end

		// drain, then give the core time to show anything extra
		wait_drained();
		steady = 1'b0;
		repeat (16) @(posedge clk);

		$display("covered %0d directed and %0d random events over %0d reload settings",
			directed_items, items_sent - directed_items, NUM_PHASES + 1);
		$display("checked %0d results: %0d rx frames, %0d ring overflows, %0d mismatches",
			results_seen, frames_out, overflows, mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== uart_buffered_tx_rx_idle_timeout_core.f =====
+incdir+hdl
hdl/ubt_pkg.sv
hdl/ubt_front.sv
hdl/ubt_back.sv
hdl/ubt_outq.sv
hdl/uart_buffered_tx_rx_idle_timeout_core.sv
hdl/ubt_port_checker.sv
sim/testbench.sv
